FILE: hw/rtl/psrg_pkg.sv
// ----------------------------------------------------------------------------
// psrg_pkg: shared constants for the multisample resolve block
// Default widths, register map and channel count.
// ----------------------------------------------------------------------------
package psrg_pkg;
	localparam int SUM_WIDTH_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int NCH               = 3;
	localparam int Q_W               = 17;  // quotient bits, top bit flags saturation
	localparam int ROOT_W            = 8;
	localparam int SPP_W             = 16;
	localparam int ADDR_W            = 3;
	localparam logic [ADDR_W-1:0] REG_SPP = 3'd0;
	localparam logic [SPP_W-1:0]  SPP_RESET = 16'd1;
endpackage

FILE: hw/rtl/psrg_div_cell.sv
// ----------------------------------------------------------------------------
// psrg_div_cell: one restoring-division cell
// Settles one quotient bit for all three channels and hands the beat on.
// ----------------------------------------------------------------------------
module psrg_div_cell #(
	parameter int W   = 41,
	parameter int DW  = 16,
	parameter int BIT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [DW-1:0]                       den,
	input  logic [psrg_pkg::NCH-1:0][W-1:0]     rem_in,
	input  logic [psrg_pkg::NCH-1:0][psrg_pkg::Q_W-1:0] q_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [psrg_pkg::NCH-1:0][W-1:0]     rem_out,
	output logic [psrg_pkg::NCH-1:0][psrg_pkg::Q_W-1:0] q_out
);
	import psrg_pkg::*;

	logic                       v_q;
	logic [NCH-1:0][W-1:0]      rem_q;
	logic [NCH-1:0][Q_W-1:0]    q_q;
	logic [NCH-1:0][W-1:0]      rem_nx;
	logic [NCH-1:0][Q_W-1:0]    q_nx;
	logic [W-1:0]               dsh;

	assign dsh = W'(den) << BIT;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			rem_nx[c] = rem_in[c];
			q_nx[c]   = q_in[c];
			if (rem_in[c] >= dsh) begin
				rem_nx[c]    = rem_in[c] - dsh;
				q_nx[c][BIT] = 1'b1;
			end
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign rem_out   = rem_q;
	assign q_out     = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q <= rem_nx;
			q_q   <= q_nx;
		end
	end
endmodule

FILE: hw/rtl/psrg_root_cell.sv
// ----------------------------------------------------------------------------
// psrg_root_cell: one square-root cell
// Tries one root bit per channel against the quotient and hands the beat on.
// ----------------------------------------------------------------------------
module psrg_root_cell #(
	parameter int BIT = 7
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [psrg_pkg::NCH-1:0][psrg_pkg::Q_W-1:0]    q_in,
	input  logic [psrg_pkg::NCH-1:0][psrg_pkg::ROOT_W-1:0] root_in,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [psrg_pkg::NCH-1:0][psrg_pkg::Q_W-1:0]    q_out,
	output logic [psrg_pkg::NCH-1:0][psrg_pkg::ROOT_W-1:0] root_out
);
	import psrg_pkg::*;

	logic                         v_q;
	logic [NCH-1:0][Q_W-1:0]      q_q;
	logic [NCH-1:0][ROOT_W-1:0]   root_q;
	logic [NCH-1:0][ROOT_W-1:0]   root_nx;
	logic [ROOT_W-1:0]            trial;
	logic [2*ROOT_W-1:0]          sq;

	always_comb begin
		trial = '0;
		sq    = '0;
		for (int c = 0; c < NCH; c++) begin
			trial      = root_in[c] | (ROOT_W'(1) << BIT);
			sq         = trial * trial;
			root_nx[c] = (Q_W'(sq) <= q_in[c]) ? trial : root_in[c];
		end
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign q_out     = q_q;
	assign root_out  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_q    <= q_in;
			root_q <= root_nx;
		end
	end
endmodule

FILE: hw/rtl/pixel_sample_resolve_gamma2_top.sv
// ----------------------------------------------------------------------------
// pixel_sample_resolve_gamma2_top: multisample resolve with gamma 2 to 8 bit
// Divides each color sum by the sample count, takes the square root, clamps.
// ----------------------------------------------------------------------------
// One pixel beat is accepted per clock unless a stalled output has backed up to the
// input. Each beat passes 17 division cells that settle one quotient bit each (the top bit marks
// a quotient of 65536 or more, which saturates to 255), then 8 root cells settle
// one bit of the square root each. Every cell has its own valid, so a stalled
// output only backs up as far as the pipeline is full. The sample count register
// sits at byte address 0; a value of 0 acts as 1. Write it only while idle.
module pixel_sample_resolve_gamma2_top #(
	parameter int SUM_WIDTH     = psrg_pkg::SUM_WIDTH_DEF,
	parameter int FRACTION_BITS = psrg_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [psrg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        valid,
	output logic                        ready,
	input  logic [SUM_WIDTH-1:0]        sum_red,
	input  logic [SUM_WIDTH-1:0]        sum_green,
	input  logic [SUM_WIDTH-1:0]        sum_blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  red_out,
	output logic [7:0]                  green_out,
	output logic [7:0]                  blue_out
);
	import psrg_pkg::*;

	localparam int UP   = (FRACTION_BITS <= 16) ? 16 - FRACTION_BITS : 0;
	localparam int DOWN = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
	localparam int NW   = SUM_WIDTH + UP;
	localparam int DW   = SPP_W + DOWN;
	localparam int W    = ((NW > DW + 16) ? NW : DW + 16) + 1;
	localparam int NDIV = Q_W;
	localparam int NRT  = ROOT_W;

	logic [SPP_W-1:0] spp_q;
	logic [DW-1:0]    den;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SPP) ? 32'(spp_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SPP) begin
			spp_q <= pwdata[SPP_W-1:0];
		end
	end

	assign den = DW'((spp_q == '0) ? SPP_RESET : spp_q) << DOWN;

	// division chain
	logic                      dv [0:NDIV];
	logic                      dr [0:NDIV];
	logic [NCH-1:0][W-1:0]     rem_c [0:NDIV];
	logic [NCH-1:0][Q_W-1:0]   q_c [0:NDIV];

	assign dv[0]    = valid;
	assign ready    = dr[0];
	assign rem_c[0] = {W'(sum_blue) << UP, W'(sum_green) << UP, W'(sum_red) << UP};
	assign q_c[0]   = '0;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		psrg_div_cell #(.W(W), .DW(DW), .BIT(NDIV - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv[k]),
			.in_ready (dr[k]),
			.den      (den),
			.rem_in   (rem_c[k]),
			.q_in     (q_c[k]),
			.out_valid(dv[k+1]),
			.out_ready(dr[k+1]),
			.rem_out  (rem_c[k+1]),
			.q_out    (q_c[k+1])
		);
	end

	// root chain
	logic                        rv [0:NRT];
	logic                        rr [0:NRT];
	logic [NCH-1:0][Q_W-1:0]     rq [0:NRT];
	logic [NCH-1:0][ROOT_W-1:0]  rt [0:NRT];

	assign rv[0]      = dv[NDIV];
	assign dr[NDIV]   = rr[0];
	assign rq[0]      = q_c[NDIV];
	assign rt[0]      = '0;
	assign out_valid  = rv[NRT];
	assign rr[NRT]    = out_ready;

	for (genvar k = 0; k < NRT; k++) begin : g_root
		psrg_root_cell #(.BIT(NRT - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (rv[k]),
			.in_ready (rr[k]),
			.q_in     (rq[k]),
			.root_in  (rt[k]),
			.out_valid(rv[k+1]),
			.out_ready(rr[k+1]),
			.q_out    (rq[k+1]),
			.root_out (rt[k+1])
		);
	end

	// saturated quotient overrides the root
	assign red_out   = rq[NRT][0][Q_W-1] ? 8'hFF : rt[NRT][0];
	assign green_out = rq[NRT][1][Q_W-1] ? 8'hFF : rt[NRT][1];
	assign blue_out  = rq[NRT][2][Q_W-1] ? 8'hFF : rt[NRT][2];

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rq[NRT][0][Q_W-1] |-> red_out == 8'hFF)
		else $error("saturated red not clamped");

	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rq[NRT][0][Q_W-1] |->
			Q_W'(rt[NRT][0]) * Q_W'(rt[NRT][0]) <= rq[NRT][0])
		else $error("red root too large");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(green_out))
		else $error("output beat dropped under stall");
endmodule
